// ----- rtl/tsch_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// TSCH slot scheduler package
// Shared types, codes and channel tables of the slot scheduler.
// ----------------------------------------------------------------------------
package tsch_pkg;

  localparam int REG_CHANNELS = 37;
  localparam int ADV_CHANNELS = 3;

  localparam int MOD_W = 41;
  localparam int MOD_CNT_W = $clog2(MOD_W);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ASSIGN  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_BEACON   = 2'd0,
    KIND_SHARED   = 2'd1,
    KIND_UPLINK   = 2'd2,
    KIND_DOWNLINK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_SLEEP = 2'd0,
    ACT_TX    = 2'd1,
    ACT_RX    = 2'd2
  } action_t;

  localparam logic [7:0] CFG_GATEWAY = 8'd0;
  localparam logic [7:0] CFG_OWN_ID  = 8'd1;
  localparam logic [7:0] CFG_COUNT   = 8'd2;
  localparam logic [7:0] CFG_LISTEN  = 8'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  offset;
    logic [63:0] owner;
  } cell_t;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] dividend;
    logic [7:0]       divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } mod_rsp_t;

  localparam logic [6:0] REG_FREQ [REG_CHANNELS] = '{
    7'd4,  7'd6,  7'd8,  7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20, 7'd22,
    7'd24, 7'd28, 7'd30, 7'd32, 7'd34, 7'd36, 7'd38, 7'd40, 7'd42, 7'd44,
    7'd46, 7'd48, 7'd50, 7'd52, 7'd54, 7'd56, 7'd58, 7'd60, 7'd62, 7'd64,
    7'd66, 7'd68, 7'd70, 7'd72, 7'd74, 7'd76, 7'd78
  };

  localparam logic [6:0] ADV_FREQ [ADV_CHANNELS] = '{7'd2, 7'd26, 7'd80};

endpackage
`default_nettype wire

// ----- rtl/tsch_slot_scheduler_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// TSCH slot scheduler core
// Channel-hopping slot scheduler over a RAM of schedule cells.
// ----------------------------------------------------------------------------
// A tick makes two passes of the shared remainder unit (cell index, then hop
// channel) with a cell read between them, and a third pass for the advert
// channel when an ordinary node listens on an unowned uplink slot. A cell write
// goes through S_WR to S_DONE. Assign and release walk the cell RAM, reading
// and checking one cell at a time, up to the clamped count. One request at a
// time. Reset restores the register defaults and clears the slotframe count.
module tsch_slot_scheduler_core #(
  parameter int MAX_CELLS = 64,
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [39:0] slot_number,
  input  wire logic [5:0]  cell_position,
  input  wire logic [1:0]  cell_kind,
  input  wire logic [7:0]  hop_offset,
  input  wire logic [63:0] node_ident,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       slot_action,
  output logic [6:0]       frequency,
  output logic [1:0]       slot_kind,
  output logic             success
);

  typedef enum logic [3:0] {
    S_IDLE, S_IDXW, S_RD, S_RDW, S_FREQW, S_ADVW, S_WR, S_SRD, S_SCHK, S_DONE
  } state_t;

  state_t state;

  logic        node_is_gateway;
  logic [63:0] own_device_id;
  logic [6:0]  cell_count;
  logic        listen_unowned_uplink;
  logic [31:0] slotframe_count;

  tsch_pkg::op_t   op;
  logic [39:0]     asn;
  logic [5:0]      pos;
  logic [1:0]      kind_in;
  logic [7:0]      offset_in;
  logic [63:0]     ident;

  logic [AW-1:0]   idx;
  logic            idx_zero;
  logic [6:0]      cnt;
  logic            adv_needed;
  logic [1:0]      res_act;
  logic [6:0]      res_freq;
  logic [1:0]      res_kind;
  logic            res_ok;

  logic [6:0]      n_cells;
  logic            pos_ok;
  logic            hit;
  logic            last_cell;

  tsch_pkg::mod_req_t mod_req;
  tsch_pkg::mod_rsp_t mod_rsp;

  tsch_pkg::cell_t  cur_cell;
  tsch_pkg::cell_t  wcell;
  logic [$bits(tsch_pkg::cell_t)-1:0] rdata;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign cur_cell  = tsch_pkg::cell_t'(rdata);

  always_comb begin
    if (cell_count == 7'd0) begin
      n_cells = 7'd1;
    end else if ({2'b00, cell_count} > 9'(MAX_CELLS)) begin
      n_cells = 7'(MAX_CELLS);
    end else begin
      n_cells = cell_count;
    end
  end

  assign pos_ok    = ({3'b000, pos} < 9'(MAX_CELLS));
  assign last_cell = (({1'b0, cnt} + 8'd1) == {1'b0, n_cells});
  assign hit = (cur_cell.kind == tsch_pkg::KIND_UPLINK) &&
               (((op == tsch_pkg::OP_ASSIGN) && (cur_cell.owner == 64'd0)) ||
                ((op == tsch_pkg::OP_RELEASE) && (cur_cell.owner == ident)));

  always_comb begin
    if (state == S_WR) begin
      we          = pos_ok;
      waddr       = AW'(pos);
      wcell.kind  = kind_in;
      wcell.offset = offset_in;
      wcell.owner = ident;
    end else begin
      we          = (state == S_SCHK) && hit;
      waddr       = AW'(cnt);
      wcell.kind  = cur_cell.kind;
      wcell.offset = cur_cell.offset;
      wcell.owner = (op == tsch_pkg::OP_ASSIGN) ? ident : 64'd0;
    end
    raddr = (state == S_SRD) ? AW'(cnt) : idx;
  end

  tsch_ram #(
    .WIDTH ($bits(tsch_pkg::cell_t)),
    .DEPTH (MAX_CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wcell),
    .raddr (raddr),
    .rdata (rdata)
  );

  tsch_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_is_gateway       <= 1'b0;
      own_device_id         <= 64'd0;
      cell_count            <= 7'd1;
      listen_unowned_uplink <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsch_pkg::CFG_GATEWAY: node_is_gateway       <= cfg_data[0];
        tsch_pkg::CFG_OWN_ID:  own_device_id         <= cfg_data;
        tsch_pkg::CFG_COUNT:   cell_count            <= cfg_data[6:0];
        tsch_pkg::CFG_LISTEN:  listen_unowned_uplink <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      mod_req.start   <= 1'b0;
      slotframe_count <= 32'd0;
    end else begin
      mod_req.start <= ((state == S_IDLE) && in_valid &&
                        (operation == tsch_pkg::OP_TICK)) ||
                       (state == S_RDW) ||
                       ((state == S_FREQW) && mod_rsp.done && adv_needed);
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= tsch_pkg::op_t'(operation);
            asn       <= slot_number;
            pos       <= cell_position;
            kind_in   <= cell_kind;
            offset_in <= hop_offset;
            ident     <= node_ident;
            cnt       <= 7'd0;
            res_act   <= tsch_pkg::ACT_SLEEP;
            res_freq  <= 7'd0;
            res_kind  <= 2'd0;
            res_ok    <= 1'b1;
            case (tsch_pkg::op_t'(operation))
              tsch_pkg::OP_TICK: begin
                mod_req.dividend <= {1'b0, slot_number};
                mod_req.divisor  <= {1'b0, n_cells};
                state            <= S_IDXW;
              end
              tsch_pkg::OP_WRITE: state <= S_WR;
              default: state <= S_SRD;
            endcase
          end
        end
        S_IDXW: begin
          if (mod_rsp.done) begin
            idx      <= AW'(mod_rsp.rem);
            idx_zero <= (mod_rsp.rem == 8'd0);
            state    <= S_RD;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          res_kind   <= cur_cell.kind;
          adv_needed <= 1'b0;
          if (node_is_gateway) begin
            res_act <= ((cur_cell.kind == tsch_pkg::KIND_BEACON) ||
                        (cur_cell.kind == tsch_pkg::KIND_DOWNLINK)) ?
                       tsch_pkg::ACT_TX : tsch_pkg::ACT_RX;
          end else if ((cur_cell.kind == tsch_pkg::KIND_BEACON) ||
                       (cur_cell.kind == tsch_pkg::KIND_DOWNLINK)) begin
            res_act <= tsch_pkg::ACT_RX;
          end else if ((cur_cell.kind == tsch_pkg::KIND_SHARED) ||
                       (cur_cell.owner == own_device_id)) begin
            res_act <= tsch_pkg::ACT_TX;
          end else if (listen_unowned_uplink) begin
            res_act    <= tsch_pkg::ACT_RX;
            adv_needed <= 1'b1;
          end
          if (cur_cell.kind == tsch_pkg::KIND_BEACON) begin
            mod_req.dividend <= {1'b0, asn};
            mod_req.divisor  <= 8'(tsch_pkg::ADV_CHANNELS);
          end else begin
            mod_req.dividend <= {1'b0, asn} + 41'(cur_cell.offset);
            mod_req.divisor  <= 8'(tsch_pkg::REG_CHANNELS);
          end
          state <= S_FREQW;
        end
        S_FREQW: begin
          if (mod_rsp.done) begin
            if (res_kind == tsch_pkg::KIND_BEACON) begin
              res_freq <= tsch_pkg::ADV_FREQ[mod_rsp.rem[1:0]];
            end else begin
              res_freq <= tsch_pkg::REG_FREQ[mod_rsp.rem[5:0]];
            end
            if (adv_needed) begin
              mod_req.dividend <= 41'(slotframe_count);
              mod_req.divisor  <= 8'(tsch_pkg::ADV_CHANNELS);
              state            <= S_ADVW;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ADVW: begin
          if (mod_rsp.done) begin
            res_freq <= tsch_pkg::ADV_FREQ[mod_rsp.rem[1:0]];
            state    <= S_DONE;
          end
        end
        S_WR: state <= S_DONE;
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (hit) begin
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else if (last_cell) begin
            res_ok <= 1'b0;
            state  <= S_DONE;
          end else begin
            cnt   <= cnt + 7'd1;
            state <= S_SRD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            slot_action  <= res_act;
            frequency    <= res_freq;
            slot_kind    <= res_kind;
            success      <= res_ok;
            if ((op == tsch_pkg::OP_TICK) && idx_zero && (asn != 40'd0)) begin
              slotframe_count <= slotframe_count + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tsch_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/tsch_mod_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring remainder of a 41-bit value by an 8-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module tsch_mod_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tsch_pkg::mod_req_t req,
  output tsch_pkg::mod_rsp_t      rsp
);

  logic                          busy;
  logic                          done;
  logic [tsch_pkg::MOD_CNT_W-1:0] cnt;
  logic [tsch_pkg::MOD_W-1:0]     sh;
  logic [7:0]                     divisor;
  logic [7:0]                     rem;
  logic [8:0]                     trial;
  logic [7:0]                     rem_next;

  always_comb begin
    trial = {rem, sh[tsch_pkg::MOD_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = 8'(trial - {1'b0, divisor});
    end else begin
      rem_next = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy    <= 1'b1;
        done    <= 1'b0;
        cnt     <= '0;
        sh      <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem <= rem_next;
        sh  <= {sh[tsch_pkg::MOD_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == tsch_pkg::MOD_CNT_W'(tsch_pkg::MOD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp = {done, rem};

endmodule
`default_nettype wire

// ----- test/tb_tsch_slot_scheduler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot scheduler core testbench
// Loads schedules into the cell table, ticks through slotframes and assigns and
// releases uplink cells under several register settings. Every request is
// predicted in the bench, and each result is checked in order against the
// prediction, with random idling on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_tsch_slot_scheduler_core;
  import tsch_pkg::*;

  localparam int CELLS = 64;
  localparam int HOLD_CYCLES = 400;
  localparam logic [7:0] CFG_NONE = 8'hFF;

  typedef struct packed {
    action_t    action;
    logic [6:0] freq;
    kind_t      kind;
    logic       ok;
  } slot_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [63:0] cfg_data = 64'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = 2'd0;
  logic [39:0] slot_number = 40'd0;
  logic [5:0]  cell_position = 6'd0;
  logic [1:0]  cell_kind = 2'd0;
  logic [7:0]  hop_offset = 8'd0;
  logic [63:0] node_ident = 64'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  slot_action;
  logic [6:0]  frequency;
  logic [1:0]  slot_kind;
  logic        success;

  int tx_idle_pct = 14;
  int rx_idle_pct = 56;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int mismatch_count = 0;

  slot_result_t pending_slots[$];

  kind_t       sched_kind  [CELLS];
  logic [7:0]  sched_offset[CELLS];
  logic [63:0] sched_owner [CELLS];
  logic [31:0] frame_count = 32'd0;
  logic        cfg_gateway = 1'b0;
  logic [63:0] cfg_own_id = 64'd0;
  logic [6:0]  cfg_cells = 7'd1;
  logic        cfg_listen = 1'b0;

  tsch_slot_scheduler_core #(.MAX_CELLS(CELLS)) DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .slot_number(slot_number), .cell_position(cell_position),
    .cell_kind(cell_kind), .hop_offset(hop_offset), .node_ident(node_ident),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot_action(slot_action), .frequency(frequency), .slot_kind(slot_kind),
    .success(success)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned frame_len();
    int unsigned n;
    n = cfg_cells;
    if (n == 0) n = 1;
    if (n > CELLS) n = CELLS;
    return n;
  endfunction

  function automatic logic [6:0] regular_mhz(longint unsigned v);
    int unsigned ch;
    ch = int'(v % REG_CHANNELS);
    return 7'((ch < 11) ? 4 + 2 * ch : 6 + 2 * ch);
  endfunction

  function automatic logic [6:0] advert_mhz(longint unsigned v);
    case (v % ADV_CHANNELS)
      0: return 7'd2;
      1: return 7'd26;
      default: return 7'd80;
    endcase
  endfunction

  function automatic slot_result_t predict_slot(op_t op, logic [39:0] asn, logic [5:0] pos,
                                                kind_t kind, logic [7:0] ofs, logic [63:0] id);
    slot_result_t r;
    longint unsigned a;
    int unsigned n;
    int unsigned idx;
    kind_t k;
    logic found;
    r.action = ACT_SLEEP;
    r.freq = 7'd0;
    r.kind = KIND_BEACON;
    r.ok = 1'b1;
    a = asn;
    n = frame_len();
    found = 1'b0;
    case (op)
      OP_TICK: begin
        idx = int'(a % n);
        k = sched_kind[idx];
        r.kind = k;
        r.freq = (k == KIND_BEACON) ? advert_mhz(a) : regular_mhz(a + sched_offset[idx]);
        if (cfg_gateway) begin
          r.action = (k == KIND_BEACON || k == KIND_DOWNLINK) ? ACT_TX : ACT_RX;
        end else if (k == KIND_BEACON || k == KIND_DOWNLINK) begin
          r.action = ACT_RX;
        end else if (k == KIND_SHARED) begin
          r.action = ACT_TX;
        end else if (sched_owner[idx] == cfg_own_id) begin
          r.action = ACT_TX;
        end else if (cfg_listen) begin
          r.action = ACT_RX;
          r.freq = advert_mhz(frame_count);
        end
        if (a != 0 && idx == 0) frame_count = frame_count + 32'd1;
      end
      OP_WRITE: begin
        sched_kind[pos] = kind;
        sched_offset[pos] = ofs;
        sched_owner[pos] = id;
      end
      default: begin
        for (int i = 0; i < n && !found; i++) begin
          if (sched_kind[i] == KIND_UPLINK) begin
            if (op == OP_ASSIGN && sched_owner[i] == 64'd0) begin
              sched_owner[i] = id;
              found = 1'b1;
            end else if (op == OP_RELEASE && sched_owner[i] == id) begin
              sched_owner[i] = 64'd0;
              found = 1'b1;
            end
          end
        end
        r.ok = found;
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pick_ident();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 64'd0;
    if (r < 50) return cfg_own_id;
    if (r < 90) return 64'($urandom_range(1, 6));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [39:0] pick_slot();
    logic [63:0] r64;
    int unsigned r;
    r64 = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 40) return r64[39:0];
    if (r < 60) return 40'($urandom_range(300));
    if (r < 80) return 40'(frame_len() * $urandom_range(1, 1 << 20));
    if (r < 90) return 40'd0;
    return ~40'($urandom_range(300));
  endfunction

  task automatic send_request(op_t op, logic [39:0] asn, logic [5:0] pos, kind_t kind,
                              logic [7:0] ofs, logic [63:0] id);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    operation <= op;
    slot_number <= asn;
    cell_position <= pos;
    cell_kind <= kind;
    hop_offset <= ofs;
    node_ident <= id;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_slots.push_back(predict_slot(op, asn, pos, kind, ofs, id));
  endtask

  task automatic send_tick(logic [39:0] asn);
    send_request(OP_TICK, asn, 6'($urandom_range(63)), kind_t'($urandom_range(3)),
                 8'($urandom_range(255)), {$urandom, $urandom});
  endtask

  task automatic send_random_request();
    logic [63:0] r64;
    int unsigned r;
    op_t op;
    kind_t kind;
    r64 = {$urandom, $urandom};
    r = $urandom_range(99);
    op = (r < 55) ? OP_TICK : (r < 70) ? OP_WRITE : (r < 85) ? OP_ASSIGN : OP_RELEASE;
    kind = ($urandom_range(99) < 40) ? KIND_UPLINK : kind_t'($urandom_range(3));
    send_request(op, pick_slot(), 6'($urandom_range(63)), kind, r64[7:0],
                 (op == OP_WRITE && r64[8]) ? 64'd0 : pick_ident());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [63:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GATEWAY: cfg_gateway = data[0];
      CFG_OWN_ID:  cfg_own_id = data;
      CFG_COUNT:   cfg_cells = data[6:0];
      CFG_LISTEN:  cfg_listen = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_request(OP_WRITE, 40'd0, 6'd0, KIND_BEACON, 8'hFF, ~64'd0);
    send_tick(40'd0);
    send_tick(~40'd0);
    send_tick(40'd5);
    send_request(OP_ASSIGN, 40'd0, 6'd0, KIND_BEACON, 8'd0, 64'd5);
    send_request(OP_RELEASE, ~40'd0, 6'h3F, KIND_DOWNLINK, 8'hFF, 64'd0);
  endtask

  task automatic test_small_frame();
    send_request(OP_WRITE, 40'd0, 6'd1, KIND_SHARED, 8'h80, 64'h1234);
    send_request(OP_WRITE, 40'd0, 6'd2, KIND_UPLINK, 8'h01, 64'd0);
    send_request(OP_WRITE, 40'd0, 6'd3, KIND_DOWNLINK, 8'hFF, 64'd0);
    wait_idle();
    write_reg(CFG_COUNT, 64'd4);
    write_reg(CFG_OWN_ID, ~64'd0);
    send_tick(40'd1);
    send_tick(40'd2);
    send_tick(40'd3);
    send_request(OP_ASSIGN, 40'd0, 6'd0, KIND_BEACON, 8'd0, 64'd0);
    send_request(OP_RELEASE, 40'd0, 6'd0, KIND_BEACON, 8'd0, 64'd0);
    send_request(OP_ASSIGN, 40'd0, 6'd0, KIND_BEACON, 8'd0, ~64'd0);
    send_tick(40'd6);
    send_request(OP_ASSIGN, 40'd0, 6'd0, KIND_BEACON, 8'd0, 64'd7);
    send_request(OP_RELEASE, 40'd0, 6'd0, KIND_BEACON, 8'd0, ~64'd0);
    send_tick(40'd6);
  endtask

  task automatic test_mode_changes();
    wait_idle();
    write_reg(CFG_LISTEN, 64'd1);
    send_tick(40'd10);
    wait_idle();
    write_reg(CFG_GATEWAY, 64'd1);
    for (int s = 4; s < 8; s++) send_tick(40'(s));
    wait_idle();
    write_reg(CFG_NONE, ~64'd0);
    send_tick(40'd9);
  endtask

  task automatic apply_settings(int k);
    logic [63:0] r64;
    logic [6:0] size;
    r64 = {$urandom, $urandom};
    case (k)
      0: size = 7'd64;
      1: size = 7'd0;
      2: size = 7'd127;
      3: size = 7'd1;
      4: size = 7'd63;
      5: size = 7'd65;
      6: size = 7'd2;
      default: size = 7'($urandom_range(1, CELLS));
    endcase
    wait_idle();
    write_reg(CFG_COUNT, {r64[63:7], size});
    write_reg(CFG_GATEWAY, {r64[63:1], k[0]});
    write_reg(CFG_LISTEN, {r64[62:0], k[1]});
    write_reg(CFG_OWN_ID, (k == 0) ? 64'd0 : (k == 1) ? ~64'd0 :
              k[2] ? {$urandom, $urandom} : 64'($urandom_range(1, 6)));
    if (k % 3 == 2) write_reg(8'($urandom_range(4, 255)), r64);
  endtask

  task automatic test_random_traffic(int phase);
    case (phase)
      0: begin
        tx_idle_pct = 14;
        rx_idle_pct = 56;
      end
      1: begin
        tx_idle_pct = 56;
        rx_idle_pct = 14;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
    for (int c = 0; c < CELLS; c++) begin
      send_request(OP_WRITE, pick_slot(), 6'(c),
                   ($urandom_range(99) < 40) ? KIND_UPLINK : kind_t'($urandom_range(3)),
                   8'($urandom_range(255)), $urandom_range(1) ? 64'd0 : pick_ident());
    end
    for (int s = 0; s < 3; s++) begin
      apply_settings(3 * phase + s);
      repeat (135) send_random_request();
    end
  endtask

  task automatic test_result_backpressure();
    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (10) send_tick(pick_slot());
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_slots
    slot_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_slots.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: action %0d freq %0d kind %0d success %0d",
                   slot_action, frequency, slot_kind, success);
      end else begin
        want = pending_slots.pop_front();
        if (slot_action !== want.action || frequency !== want.freq ||
            slot_kind !== want.kind || success !== want.ok) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch (expected/actual): action %0d/%0d freq %0d/%0d kind %0d/%0d ok %0d/%0d",
                     want.action, slot_action, want.freq, frequency,
                     want.kind, slot_kind, want.ok, success);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_small_frame();
    test_mode_changes();
    for (int p = 0; p < 3; p++) test_random_traffic(p);
    test_result_backpressure();
    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_slots.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
